[hw/rtl/cps_pkg.sv]
// Shared types for the convex polygon span block.
// Holds the controller state enum, opcode and status codes, and the command/status structs.
// No dependencies.
`default_nettype none
package cps_pkg;

  localparam logic OpAdd       = 1'b0;
  localparam logic OpQuery     = 1'b1;
  localparam logic StatusOk    = 1'b0;
  localparam logic StatusEmpty = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SIDE,
    ST_RD,
    ST_CHK,
    ST_MUL0,
    ST_MUL1,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } cps_state_e;

  typedef struct packed {
    logic add_we;
    logic load_q;
    logic side_next;
    logic take_direct;
    logic set_empty;
    logic walk_init;
    logic walk_step;
    logic interp_init;
    logic mul_lo;
    logic mul_hi;
    logic div_step;
    logic finish;
  } cps_cmd_t;

  typedef struct packed {
    logic empty;
    logic direct;
    logic side_right;
    logic go;
    logic div_done;
  } cps_stat_t;

endpackage
`default_nettype wire

[hw/rtl/convex_polygon_span.sv]
// Top level of the convex polygon span block.
// Instantiates cps_ctrl and cps_dp; depends on cps_pkg.
//
// Usage:
//  Input channel (in_valid_i / in_stall_o) carries opcode_i, x_coord_i,
//  y_coord_i. Opcode 0 stores a vertex (clockwise order, Q16.16); a vertex
//  past MAX_VERTICES is dropped. Opcode 1 queries the span at y_coord_i.
//  Output channel (out_valid_o / out_stall_i) returns left_x_o, right_x_o
//  and status_o for each query; status 1 means no vertex stored.
//  One item is in work at a time. An add is stored in the idle state. A
//  query handles each side in turn: when y is outside the polygon height
//  the side is answered directly; otherwise the walk reads and checks
//  one vertex at a time from the single-port vertex memory, then the
//  shared multiplier forms the low and high partial products, and the
//  one-bit-per-cycle restoring divider and a final add give the x;
//  then the result is presented.
//  in_stall_o stays high while a query is in work or its result waits.
//  The result holds on the outputs while out_stall_i is high.
//  Reset clears the vertex count and extreme indices; memory contents
//  are left as they are and read only after being written.
`default_nettype none
module convex_polygon_span #(
  parameter int MAX_VERTICES = 16
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire               opcode_i,
  input  wire signed [31:0] x_coord_i,
  input  wire signed [31:0] y_coord_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output logic signed [31:0] left_x_o,
  output logic signed [31:0] right_x_o,
  output logic              status_o
);
  import cps_pkg::*;

  cps_cmd_t  cmd;
  cps_stat_t stat;

  cps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .opcode_i    (opcode_i),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  cps_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .x_coord_i (x_coord_i),
    .y_coord_i (y_coord_i),
    .left_x_o  (left_x_o),
    .right_x_o (right_x_o),
    .status_o  (status_o)
  );

endmodule
`default_nettype wire

[hw/rtl/cps_ctrl.sv]
// Controller state machine of the convex polygon span block.
// Depends on cps_pkg; drives cps_dp through cps_cmd_t.
`default_nettype none
module cps_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  input  wire              opcode_i,
  input  wire              out_stall_i,
  input  cps_pkg::cps_stat_t stat_i,
  output cps_pkg::cps_cmd_t  cmd_o,
  output logic             in_stall_o,
  output logic             out_valid_o
);
  import cps_pkg::*;

  cps_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && opcode_i == OpQuery) state_d = ST_SIDE;
      end
      ST_SIDE: begin
        if (stat_i.empty) state_d = ST_OUT;
        else if (stat_i.direct) begin
          if (stat_i.side_right) state_d = ST_OUT;
        end else state_d = ST_RD;
      end
      ST_RD:   state_d = ST_CHK;
      ST_CHK:  state_d = stat_i.go ? ST_RD : ST_MUL0;
      ST_MUL0: state_d = ST_MUL1;
      ST_MUL1: state_d = ST_DIV;
      ST_DIV: begin
        if (stat_i.div_done) state_d = ST_FIN;
      end
      ST_FIN:  state_d = stat_i.side_right ? ST_OUT : ST_SIDE;
      ST_OUT: begin
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o     = 1'b0;
        cmd_o.add_we   = in_valid_i && opcode_i == OpAdd;
        cmd_o.load_q   = in_valid_i && opcode_i == OpQuery;
      end
      ST_SIDE: begin
        if (stat_i.empty) cmd_o.set_empty = 1'b1;
        else if (stat_i.direct) begin
          cmd_o.take_direct = 1'b1;
          cmd_o.side_next   = !stat_i.side_right;
        end else cmd_o.walk_init = 1'b1;
      end
      ST_RD: ;
      ST_CHK: begin
        cmd_o.walk_step   = stat_i.go;
        cmd_o.interp_init = !stat_i.go;
      end
      ST_MUL0: cmd_o.mul_lo = 1'b1;
      ST_MUL1: cmd_o.mul_hi = 1'b1;
      ST_DIV:  cmd_o.div_step = 1'b1;
      ST_FIN: begin
        cmd_o.finish    = 1'b1;
        cmd_o.side_next = !stat_i.side_right;
      end
      ST_OUT: out_valid_o = 1'b1;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/cps_dp.sv]
// Datapath of the convex polygon span block: vertex memory, extreme
// tracking, outline walk, shared multiplier and restoring divider.
// Depends on cps_pkg; controlled by cps_ctrl.
`default_nettype none
module cps_dp #(
  parameter int MAX_VERTICES = 16
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  cps_pkg::cps_cmd_t  cmd_i,
  output cps_pkg::cps_stat_t stat_o,
  input  wire  signed [31:0] x_coord_i,
  input  wire  signed [31:0] y_coord_i,
  output logic signed [31:0] left_x_o,
  output logic signed [31:0] right_x_o,
  output logic               status_o
);
  import cps_pkg::*;

  localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_VERTICES);

  logic [63:0] mem [MAX_VERTICES];
  logic [63:0] rd_q;

  logic [CW-1:0] count_q;
  logic [IW-1:0] top_idx_q, bot_idx_q, cur_q;
  logic signed [31:0] top_x_q, top_y_q, bot_x_q, bot_y_q, qy_q;
  logic signed [31:0] prev_x_q, prev_y_q, xa_q;
  logic [CW-1:0] steps_q;
  logic side_q;
  logic [32:0] mag_dx_q, mag_num_q, mag_den_q;
  logic neg_q, den_zero_q;
  logic [64:0] acc_q;
  logic [32:0] rem_q;
  logic [6:0] div_cnt_q;
  logic signed [31:0] left_q, right_q;
  logic status_q;

  logic signed [31:0] rd_x, rd_y;
  assign rd_x = rd_q[63:32];
  assign rd_y = rd_q[31:0];

  function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] i,
                                             input logic [CW-1:0] cnt);
    logic [CW:0] inc;
    inc = {{(CW+1-IW){1'b0}}, i} + 1'b1;
    return (inc >= {1'b0, cnt}) ? '0 : inc[IW-1:0];
  endfunction

  // direct answer when y is outside the polygon height on this side, or at the extreme this side's walk starts from
  logic direct;
  logic signed [31:0] direct_x;
  always_comb begin
    direct   = 1'b0;
    direct_x = top_x_q;
    if (!side_q) begin
      if (qy_q > top_y_q) begin
        direct = 1'b1; direct_x = top_x_q;
      end else if (qy_q <= bot_y_q) begin
        direct = 1'b1; direct_x = bot_x_q;
      end
    end else begin
      if (qy_q < bot_y_q) begin
        direct = 1'b1; direct_x = bot_x_q;
      end else if (qy_q >= top_y_q) begin
        direct = 1'b1; direct_x = top_x_q;
      end
    end
  end

  logic [CW:0] steps_inc;
  logic go;
  assign steps_inc = {1'b0, steps_q} + 1'b1;
  assign go = (steps_inc < {1'b0, count_q}) && (side_q ? (qy_q < rd_y) : (qy_q > rd_y));

  assign stat_o.empty      = (count_q == '0);
  assign stat_o.direct     = direct;
  assign stat_o.side_right = side_q;
  assign stat_o.go         = go;
  assign stat_o.div_done   = (div_cnt_q == 7'd64);

  // edge setup
  logic signed [32:0] dx, num, den;
  assign dx  = 33'(rd_x) - 33'(prev_x_q);
  assign num = 33'(qy_q) - 33'(prev_y_q);
  assign den = 33'(rd_y) - 33'(prev_y_q);

  // shared 33x17 multiplier
  logic [16:0] mul_b;
  logic [49:0] prod;
  assign mul_b = cmd_i.mul_hi ? {1'b0, mag_num_q[32:17]} : mag_num_q[16:0];
  assign prod  = 50'(mag_dx_q) * 50'(mul_b);

  // restoring divider step
  logic [33:0] rem_sh, rem_sub;
  logic        q_bit;
  assign rem_sh  = {rem_q, acc_q[64]};
  assign q_bit   = rem_sh >= {1'b0, mag_den_q};
  assign rem_sub = rem_sh - {1'b0, mag_den_q};

  // final add with clamp and saturation
  localparam logic [64:0] QLim = 65'd1 << 33;
  logic [33:0] qc;
  logic signed [35:0] r_sum;
  logic signed [31:0] r_sat;
  always_comb begin
    qc = (acc_q > QLim) ? 34'(QLim) : acc_q[33:0];
    r_sum = 36'(xa_q) + (neg_q ? -$signed({2'b0, qc}) : $signed({2'b0, qc}));
    if (r_sum > 36'sd2147483647) r_sat = 32'sh7fffffff;
    else if (r_sum < -36'sd2147483648) r_sat = 32'sh80000000;
    else r_sat = r_sum[31:0];
    if (den_zero_q) r_sat = xa_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_we && count_q < MaxCnt) begin
      mem[count_q[IW-1:0]] <= {x_coord_i, y_coord_i};
    end
    rd_q <= mem[cur_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      top_idx_q <= '0;
      bot_idx_q <= '0;
      side_q    <= 1'b0;
    end else begin
      if (cmd_i.add_we && count_q < MaxCnt) begin
        if (count_q == '0 || y_coord_i >= top_y_q) top_idx_q <= count_q[IW-1:0];
        if (count_q == '0 || y_coord_i <= bot_y_q) bot_idx_q <= count_q[IW-1:0];
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.load_q) side_q <= 1'b0;
      else if (cmd_i.side_next) side_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_we && count_q < MaxCnt) begin
      if (count_q == '0 || y_coord_i >= top_y_q) begin
        top_x_q <= x_coord_i; top_y_q <= y_coord_i;
      end
      if (count_q == '0 || y_coord_i <= bot_y_q) begin
        bot_x_q <= x_coord_i; bot_y_q <= y_coord_i;
      end
    end
    if (cmd_i.load_q) begin
      qy_q     <= y_coord_i;
      status_q <= StatusOk;
    end
    if (cmd_i.set_empty) begin
      left_q <= '0; right_q <= '0; status_q <= StatusEmpty;
    end
    if (cmd_i.take_direct) begin
      if (side_q) right_q <= direct_x;
      else left_q <= direct_x;
    end
    if (cmd_i.finish) begin
      if (side_q) right_q <= r_sat;
      else left_q <= r_sat;
    end
    if (cmd_i.walk_init) begin
      prev_x_q <= side_q ? top_x_q : bot_x_q;
      prev_y_q <= side_q ? top_y_q : bot_y_q;
      cur_q    <= next_idx(side_q ? top_idx_q : bot_idx_q, count_q);
      steps_q  <= '0;
    end
    if (cmd_i.walk_step) begin
      prev_x_q <= rd_x;
      prev_y_q <= rd_y;
      cur_q    <= next_idx(cur_q, count_q);
      steps_q  <= steps_inc[CW-1:0];
    end
    if (cmd_i.interp_init) begin
      xa_q       <= prev_x_q;
      mag_dx_q   <= dx[32] ? 33'(-dx) : 33'(dx);
      mag_num_q  <= num[32] ? 33'(-num) : 33'(num);
      mag_den_q  <= den[32] ? 33'(-den) : 33'(den);
      neg_q      <= dx[32] ^ num[32] ^ den[32];
      den_zero_q <= (den == '0);
    end
    if (cmd_i.mul_lo) begin
      acc_q     <= 65'(prod);
      rem_q     <= '0;
      div_cnt_q <= '0;
    end
    if (cmd_i.mul_hi) acc_q <= acc_q + 65'({17'b0, prod} << 17);
    if (cmd_i.div_step) begin
      acc_q     <= {acc_q[63:0], q_bit};
      rem_q     <= q_bit ? rem_sub[32:0] : rem_sh[32:0];
      div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  assign left_x_o  = left_q;
  assign right_x_o = right_q;
  assign status_o  = status_q;

endmodule
`default_nettype wire
